[rtl/ilir_pkg.sv]
`default_nettype none
package ilir_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 8;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_DEL  = 2'd2;

	typedef struct packed {
		logic [1:0]            mode;
		logic [DATA_WIDTH-1:0] element;
		logic [IDX_W-1:0]      position;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [DATA_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]      fill_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [IDX_W-1:0]      idx;
		logic [DATA_WIDTH-1:0] element;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/ilir_cell.sv]
`default_nettype none
module ilir_cell
	import ilir_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [IDX_W-1:0]      index,
	input  wire cell_ctl_t             ctl,
	input  wire logic [DATA_WIDTH-1:0] left,
	input  wire logic [DATA_WIDTH-1:0] right,
	output logic      [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_INS: begin
				if (index > ctl.idx)
					data_d = left;
				else if (index == ctl.idx)
					data_d = ctl.element;
			end
			CELL_DEL: begin
				if (index >= ctl.idx)
					data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

[rtl/indexed_list_insert_remove_core.sv]
`default_nettype none
// Ordered list of up to CAPACITY elements held in a row of cells, one element per cell.
// Each request (append, insert at position, remove at position, read at position) gives
// exactly one response with status, read data and the count after the request. An item
// is taken every cycle unless the output backs up; every cell picks its own value, its
// left or right neighbor's, or the new element, so the whole shift is done at once. The
// response sits in a single output register, valid the cycle after acceptance;
// a new item goes in when it is empty or is taken in the same cycle. Cells are not reset.
module indexed_list_insert_remove_core
	import ilir_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	rsp_t                  rsp_d;
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] slot [CAPACITY];
	logic                  accept;
	logic [IDX_W-1:0]      at;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign at        = (req.mode == MODE_APPEND) ? count_q[IDX_W-1:0] : req.position;

	always_comb begin
		count_d         = count_q;
		ctl.op          = CELL_HOLD;
		ctl.idx         = at;
		ctl.element     = req.element;
		rsp_d.status    = ST_OK;
		rsp_d.read_value = '0;
		unique case (req.mode)
			MODE_APPEND, MODE_INSERT: begin
				if (count_q == CNT_W'(CAPACITY))
					rsp_d.status = ST_FULL;
				else if ({1'b0, at} > count_q)
					rsp_d.status = ST_RANGE;
				else begin
					ctl.op  = CELL_INS;
					count_d = count_q + 1'b1;
				end
			end
			MODE_REMOVE, MODE_READ: begin
				if (count_q == '0)
					rsp_d.status = ST_EMPTY;
				else if ({1'b0, req.position} >= count_q)
					rsp_d.status = ST_RANGE;
				else if (req.mode == MODE_READ)
					rsp_d.read_value = slot[req.position];
				else begin
					ctl.op  = CELL_DEL;
					count_d = count_q - 1'b1;
				end
			end
			default: rsp_d.status = ST_OK;
		endcase
		if (!accept)
			ctl.op = CELL_HOLD;
		rsp_d.fill_count = count_d;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;
		if (g == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_mid_l
			assign left_data = slot[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_mid_r
			assign right_data = slot[g+1];
		end
		ilir_cell u_cell (
			.clk   (clk),
			.index (IDX_W'(g)),
			.ctl   (ctl),
			.left  (left_data),
			.right (right_data),
			.data  (slot[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted item without response");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.fill_count == count_q)
		else $error("response count differs from held count");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |-> rsp_q.read_value == '0)
		else $error("read data on failed item");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without item");
`endif

endmodule
`default_nettype wire

[tb/list_checker.sv]
`timescale 1ns / 100ps
module list_checker
	import ilir_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  rsp_t             rsp,
	output int               errors,
	output int               pending,
	output logic [CNT_W-1:0] level
);

	logic [DATA_WIDTH-1:0] cells [CAPACITY];
	logic [CNT_W-1:0]      count;
	rsp_t                  awaited [$];

	initial errors = 0;

	task automatic report_mismatch(string what, int got, int want);
		if (errors < 40) begin
			$display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
		end
		errors++;
	endtask

	function automatic rsp_t apply_request(req_t r);
		rsp_t             o;
		logic [CNT_W-1:0] at;
		o = '0;
		o.status = ST_OK;
		if (r.mode == MODE_APPEND || r.mode == MODE_INSERT) begin
			at = (r.mode == MODE_APPEND) ? count : CNT_W'(r.position);
			if (count >= CAPACITY) begin
				o.status = ST_FULL;
			end else if (at > count) begin
				o.status = ST_RANGE;
			end else begin
				for (int i = int'(count); i > int'(at); i--)
					cells[i] = cells[i-1];
				cells[at] = r.element;
				count++;
			end
		end else begin
			if (count == 0) begin
				o.status = ST_EMPTY;
			end else if (CNT_W'(r.position) >= count) begin
				o.status = ST_RANGE;
			end else if (r.mode == MODE_READ) begin
				o.read_value = cells[r.position];
			end else begin
				for (int i = int'(r.position); i + 1 < int'(count); i++)
					cells[i] = cells[i+1];
				count--;
			end
		end
		o.fill_count = count;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			count = '0;
			awaited.delete();
		end else begin
			// response first: an item accepted at this edge cannot answer yet
			if (rsp_valid && rsp_ready) begin
				if (awaited.size() == 0) begin
					report_mismatch("unexpected response, status", rsp.status, -1);
				end else begin
					want = awaited.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", rsp.read_value, want.read_value);
					if (rsp.fill_count !== want.fill_count)
						report_mismatch("fill_count", rsp.fill_count, want.fill_count);
				end
			end
			if (req_valid && req_ready)
				awaited.push_back(apply_request(req));
		end
		pending <= awaited.size();
		level   <= count;
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
	import ilir_pkg::*;

	localparam int N_RANDOM = 1850;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	int               errors;
	int               pending;
	logic [CNT_W-1:0] level;
	int               sent;
	bit               tx_steady;

	indexed_list_insert_remove_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	list_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending),
		.level     (level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL indexed_list_insert_remove_core");
		$finish;
	end

	task automatic push_item(logic [1:0] m, logic [DATA_WIDTH-1:0] e, logic [IDX_W-1:0] p);
		req_valid <= 1'b1;
		req <= '{mode: m, element: e, position: p};
		do @(posedge clk); while (!req_ready);
		sent++;
	endtask

	task automatic sender_gap();
		int n;
		int r;
		if ($urandom_range(0, 49) == 0)
			tx_steady = !tx_steady;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 55)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(6, 40);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// receiver, with one long hold-off so the output register backs up
	initial begin
		int  stall;
		bit  steady;
		bit  held_off;
		logic v;
		stall = 0;
		steady = 0;
		held_off = 0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && sent >= 700) begin
				held_off = 1;
				stall = 400;
			end
			if ($urandom_range(0, 59) == 0)
				steady = !steady;
			if (stall > 0) begin
				v = 1'b0;
				stall--;
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				v = 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 2);
			end else begin
				v = 1'b1;
			end
			rsp_ready <= v;
			@(posedge clk);
		end
	end

	initial begin
		bit   grow;
		int   r;
		int   lvl;
		logic [1:0] m;
		logic [IDX_W-1:0] p;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		sent = 0;
		tx_steady = 0;
		grow = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(MODE_READ, 8'h00, 4'd0);
		push_item(MODE_REMOVE, 8'h00, 4'd15);
		push_item(MODE_INSERT, 8'h11, 4'd1);
		push_item(MODE_INSERT, 8'hFF, 4'd0);
		push_item(MODE_APPEND, 8'h00, 4'd9);
		push_item(MODE_INSERT, 8'hA5, 4'd1);
		push_item(MODE_INSERT, 8'h5A, 4'd3);
		push_item(MODE_READ, 8'h00, 4'd3);
		push_item(MODE_READ, 8'h00, 4'd4);
		push_item(MODE_REMOVE, 8'h00, 4'd0);
		push_item(MODE_REMOVE, 8'h00, 4'd2);
		push_item(MODE_REMOVE, 8'h00, 4'd2);
		for (int i = 0; i < 14; i++) begin
			push_item(MODE_APPEND, DATA_WIDTH'(i * 17 + 3), IDX_W'(i));
			sender_gap();
		end
		push_item(MODE_APPEND, 8'h77, 4'd0);
		push_item(MODE_INSERT, 8'h88, 4'd15);
		push_item(MODE_READ, 8'h00, 4'd15);
		push_item(MODE_REMOVE, 8'h00, 4'd15);
		push_item(MODE_INSERT, 8'h3C, 4'd15);
		sender_gap();

		for (int k = 0; k < N_RANDOM; k++) begin
			lvl = int'(level);
			if ((grow && lvl == CAPACITY) || (!grow && lvl == 0))
				grow = ($urandom_range(0, 7) == 0) ? !grow : grow;
			else if ($urandom_range(0, 79) == 0)
				grow = !grow;
			r = $urandom_range(0, 99);
			if (grow)
				m = (r < 35) ? MODE_APPEND : (r < 65) ? MODE_INSERT :
				    (r < 80) ? MODE_REMOVE : MODE_READ;
			else
				m = (r < 10) ? MODE_APPEND : (r < 25) ? MODE_INSERT :
				    (r < 60) ? MODE_REMOVE : MODE_READ;
			if ($urandom_range(0, 99) < 75)
				p = IDX_W'($urandom_range(0, (lvl > CAPACITY - 1) ? CAPACITY - 1 : lvl));
			else
				p = IDX_W'($urandom_range(0, CAPACITY - 1));
			push_item(m, DATA_WIDTH'($urandom_range(0, 255)), p);
			sender_gap();
		end
		req_valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("PASS indexed_list_insert_remove_core");
		else
			$display("FAIL indexed_list_insert_remove_core");
		$finish;
	end

endmodule
